// ===== src/btt_pkg.sv =====
// shared types and constants for the brace text tokenizer
package btt_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_NAME   = 3'd1,
    MODE_STRING = 3'd2,
    MODE_SLASH  = 3'd3,
    MODE_LINE   = 3'd4,
    MODE_BLOCK  = 3'd5,
    MODE_DEAD   = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    KIND_STRING  = 3'd0,
    KIND_BRACKET = 3'd1,
    KIND_NAME    = 3'd2,
    KIND_UNKNOWN = 3'd3,
    KIND_END     = 3'd4
  } kind_t;

  localparam logic [1:0] BR_OPEN_BRACE  = 2'd0;
  localparam logic [1:0] BR_CLOSE_BRACE = 2'd1;
  localparam logic [1:0] BR_OPEN_SQ     = 2'd2;
  localparam logic [1:0] BR_CLOSE_SQ    = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LSQ   = 8'h5b;
  localparam logic [7:0] CH_RSQ   = 8'h5d;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] tbegin;
    logic [15:0] tfinish;
    logic [1:0]  code;
    logic        last;
  } token_t;

endpackage

// ===== src/brace_text_tokenizer.sv =====
// brace text tokenizer: byte stream in, tokens with offsets out
//
//  channel | direction | tdata (low bit up)                          | tuser      | tlast
//  s_*     | in        | text_byte[7:0]                              | -          | -
//  m_*     | out       | token_begin, token_finish, bracket_code, 0s | token_kind | last_of_run
//
// one byte per cycle while the output queue has room: a byte is registered, decoded in one step
// against the scan state, and its zero, one or two tokens go into a four-entry output queue
// a byte giving two tokens fills two queue entries; the queue sets the stall point
// an input byte passes the input register and then the output queue before its first token is offered
// rst (synchronous) returns to between-tokens state at offset zero and empties the queue
module brace_text_tokenizer
  import btt_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // text_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // token_begin[15:0], token_finish[31:16], bracket_code[33:32]
  output logic [2:0]  m_tuser,   // token_kind
  output logic        m_tlast    // last_of_run
);

  localparam int EW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  function automatic logic [15:0] lo16(input logic [OFFSET_BITS-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    return e[15:0];
  endfunction

  function automatic token_t mk(input kind_t k, input logic [15:0] b,
                                input logic [15:0] f, input logic [1:0] c);
    token_t t;
    t.kind = k;
    t.tbegin = b;
    t.tfinish = f;
    t.code = c;
    t.last = 1'b0;
    return t;
  endfunction

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // scan state
  mode_t                  mode, mode_next;
  logic                   after_bsl, after_bsl_next;
  logic                   star_pend, star_pend_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [OFFSET_BITS-1:0] tok_start, tok_start_next;
  logic [OFFSET_BITS-1:0] slash_off, slash_off_next;

  // output queue
  token_t               queue [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]   q_count;

  logic       room, step_fire, pop;
  token_t     res [2];
  logic [1:0] n_res;

  // byte classes
  logic c_nul, c_space, c_lf, c_quote, c_bsl, c_slash, c_star, c_brk, c_name;
  logic [1:0] brk_code;
  logic [OFFSET_BITS-1:0] nxt;
  logic [15:0] p16, nxt16, start16, slash16;

  always_comb begin
    c_nul   = (in_byte == CH_NUL);
    c_space = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_CR) ||
              (in_byte == CH_LF);
    c_lf    = (in_byte == CH_LF);
    c_quote = (in_byte == CH_QUOTE);
    c_bsl   = (in_byte == CH_BSL);
    c_slash = (in_byte == CH_SLASH);
    c_star  = (in_byte == CH_STAR);
    c_brk   = (in_byte == CH_LBRACE) || (in_byte == CH_RBRACE) || (in_byte == CH_LSQ) ||
              (in_byte == CH_RSQ);
    c_name  = (in_byte inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39]}) ||
              (in_byte == CH_UNDER) || (in_byte == CH_DOT) || (in_byte == CH_DOLLAR);
    case (in_byte)
      CH_LBRACE: brk_code = BR_OPEN_BRACE;
      CH_RBRACE: brk_code = BR_CLOSE_BRACE;
      CH_LSQ:    brk_code = BR_OPEN_SQ;
      default:   brk_code = BR_CLOSE_SQ;
    endcase
  end

  assign nxt     = (byte_offset != OFF_MAX) ? byte_offset + 1'b1 : byte_offset;
  assign p16     = lo16(byte_offset);
  assign nxt16   = lo16(nxt);
  assign start16 = lo16(tok_start);
  assign slash16 = lo16(slash_off);

  // next scan state
  always_comb begin
    logic idle_pass;
    logic end_txt;
    idle_pass = 1'b0;
    end_txt = 1'b0;
    mode_next = mode;
    after_bsl_next = after_bsl;
    star_pend_next = star_pend;
    tok_start_next = tok_start;
    slash_off_next = slash_off;
    byte_offset_next = c_nul ? byte_offset : nxt;
    case (mode)
      MODE_NAME: begin
        if (!c_name) idle_pass = 1'b1;
      end
      MODE_STRING: begin
        if (c_nul) end_txt = 1'b1;
        else if (c_lf) mode_next = MODE_DEAD;
        else if (c_quote && !after_bsl) mode_next = MODE_IDLE;
        else after_bsl_next = c_bsl;
      end
      MODE_SLASH: begin
        if (c_slash) mode_next = MODE_LINE;
        else if (c_star) begin
          star_pend_next = 1'b0;
          mode_next = MODE_BLOCK;
        end else if (c_nul) end_txt = 1'b1;
        else mode_next = MODE_DEAD;
      end
      MODE_LINE: begin
        if (c_nul) end_txt = 1'b1;
        else if (c_lf) mode_next = MODE_IDLE;
      end
      MODE_BLOCK: begin
        if (c_nul) end_txt = 1'b1;
        else if (c_slash && star_pend) begin
          star_pend_next = 1'b0;
          mode_next = MODE_IDLE;
        end else star_pend_next = c_star;
      end
      MODE_DEAD: begin
        if (c_nul) end_txt = 1'b1;
      end
      default: idle_pass = 1'b1;
    endcase
    if (idle_pass) begin
      if (c_nul) end_txt = 1'b1;
      else if (c_space || c_brk) mode_next = MODE_IDLE;
      else if (c_quote) begin
        tok_start_next = nxt;
        after_bsl_next = 1'b0;
        mode_next = MODE_STRING;
      end else if (c_slash) begin
        slash_off_next = byte_offset;
        mode_next = MODE_SLASH;
      end else if (c_name) begin
        tok_start_next = byte_offset;
        mode_next = MODE_NAME;
      end else mode_next = MODE_DEAD;
    end
    if (end_txt) begin
      mode_next = MODE_IDLE;
      after_bsl_next = 1'b0;
      star_pend_next = 1'b0;
      byte_offset_next = '0;
      tok_start_next = '0;
      slash_off_next = '0;
    end
  end

  // tokens for this byte
  always_comb begin
    logic idle_pass;
    logic [1:0] n;
    idle_pass = 1'b0;
    n = 2'd0;
    res[0] = mk(KIND_END, p16, p16, 2'd0);
    res[1] = mk(KIND_END, p16, p16, 2'd0);
    case (mode)
      MODE_NAME: begin
        if (!c_name) begin
          res[0] = mk(KIND_NAME, start16, p16, 2'd0);
          n = 2'd1;
          idle_pass = 1'b1;
        end
      end
      MODE_STRING: begin
        if (c_nul) begin
          res[0] = mk(KIND_UNKNOWN, p16, p16, 2'd0);
          n = 2'd2;
        end else if (c_lf) begin
          res[0] = mk(KIND_UNKNOWN, p16, p16, 2'd0);
          n = 2'd1;
        end else if (c_quote && !after_bsl) begin
          res[0] = mk(KIND_STRING, start16, p16, 2'd0);
          n = 2'd1;
        end
      end
      MODE_SLASH: begin
        if (!c_slash && !c_star) begin
          res[0] = mk(KIND_UNKNOWN, slash16, slash16, 2'd0);
          n = c_nul ? 2'd2 : 2'd1;
        end
      end
      MODE_LINE, MODE_BLOCK, MODE_DEAD: begin
        if (c_nul) n = 2'd1;
      end
      default: idle_pass = 1'b1;
    endcase
    if (idle_pass) begin
      if (c_nul) n = n + 2'd1;
      else if (c_brk) begin
        res[n[0]] = mk(KIND_BRACKET, p16, nxt16, brk_code);
        n = n + 2'd1;
      end else if (!c_space && !c_quote && !c_slash && !c_name) begin
        res[n[0]] = mk(KIND_UNKNOWN, p16, p16, 2'd0);
        n = n + 2'd1;
      end
    end
    res[0].last = (n == 2'd1);
    res[1].last = 1'b1;
    n_res = n;
  end

  assign pop       = m_tvalid && m_tready;
  assign room      = (q_count <= (QPTR_BITS+1)'(QUEUE_DEPTH - 2)) ||
                     ((q_count == (QPTR_BITS+1)'(QUEUE_DEPTH - 1)) && pop);
  assign step_fire = in_valid && room;
  assign s_tready  = !in_valid || step_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      after_bsl <= 1'b0;
      star_pend <= 1'b0;
      byte_offset <= '0;
      tok_start <= '0;
      slash_off <= '0;
    end else if (step_fire) begin
      mode <= mode_next;
      after_bsl <= after_bsl_next;
      star_pend <= star_pend_next;
      byte_offset <= byte_offset_next;
      tok_start <= tok_start_next;
      slash_off <= slash_off_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && (n_res != 2'd0)) begin
      queue[wr_ptr] <= res[0];
    end
    if (step_fire && (n_res == 2'd2)) begin
      queue[wr_ptr + 1'b1] <= res[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_count <= '0;
    end else begin
      if (step_fire) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      q_count <= q_count + (step_fire ? (QPTR_BITS+1)'(n_res) : '0) -
                 (QPTR_BITS+1)'(pop);
    end
  end

  assign m_tvalid = (q_count != '0);
  assign m_tdata  = {6'd0, queue[rd_ptr].code, queue[rd_ptr].tfinish, queue[rd_ptr].tbegin};
  assign m_tuser  = queue[rd_ptr].kind;
  assign m_tlast  = queue[rd_ptr].last;

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= (QPTR_BITS+1)'(QUEUE_DEPTH))
    else $error("output queue overflow");

  a_end_token: assert property (@(posedge clk) disable iff (rst)
    step_fire && c_nul |-> n_res != 2'd0)
    else $error("end of text produced no token");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    step_fire && c_nul |=> byte_offset == '0 && mode == MODE_IDLE)
    else $error("scan state not cleared after end of text");

  a_offset_step: assert property (@(posedge clk) disable iff (rst)
    step_fire && !c_nul && byte_offset != OFF_MAX |=>
      byte_offset == $past(byte_offset) + 1'b1)
    else $error("byte offset did not advance");
`endif

endmodule

// ===== tb/tb_brace_text_tokenizer.sv =====
// testbench for the brace text tokenizer: directed texts and random texts
module tb_brace_text_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import btt_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_PRINTED = 30;
  localparam int PHASE_BYTES = 470;
  localparam logic [15:0] OFFSET_MAX = 16'hffff;
  localparam logic [1:0] NO_CODE = 2'd0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;   // token_begin, token_finish, bracket_code, zero fill
  logic [2:0]  m_tuser;   // token_kind
  logic        m_tlast;

  brace_text_tokenizer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // scanner state mirrored by the predictor
  mode_t       lex_mode;
  logic        lex_escape;
  logic        lex_star;
  logic [15:0] lex_pos;
  logic [15:0] lex_start;
  logic [15:0] lex_slash;

  token_t      expected_tokens[$];
  token_t      step_tokens[$];
  token_t      want_tok;
  logic [7:0]  text_q[$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int mismatches = 0;
  int tokens_checked = 0;
  int bytes_sent = 0;
  int texts_sent = 0;
  int idle_cycles = 0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic bit is_name_byte(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == CH_UNDER || c == CH_DOT || c == CH_DOLLAR;
  endfunction

  function automatic logic [7:0] rand_name_byte();
    int r;
    r = $urandom_range(64);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    if (r == 62) return CH_UNDER;
    if (r == 63) return CH_DOT;
    return CH_DOLLAR;
  endfunction

  function automatic logic [7:0] rand_byte_except(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [7:0] r;
    do r = 8'($urandom_range(1, 255)); while (r == a || r == b || r == c);
    return r;
  endfunction

  task automatic add_token(kind_t k, logic [15:0] b, logic [15:0] f, logic [1:0] code);
    token_t t;
    t.kind = k;
    t.tbegin = b;
    t.tfinish = f;
    t.code = code;
    t.last = 1'b0;
    step_tokens.push_back(t);
  endtask

  task automatic clear_text_state();
    lex_mode = MODE_IDLE;
    lex_escape = 1'b0;
    lex_star = 1'b0;
    lex_pos = '0;
    lex_start = '0;
    lex_slash = '0;
  endtask

  task automatic lex_end(logic [15:0] p);
    add_token(KIND_END, p, p, NO_CODE);
    clear_text_state();
  endtask

  task automatic lex_fresh(logic [7:0] c, logic [15:0] p, logic [15:0] nxt);
    if (c == CH_NUL) begin
      lex_end(p);
    end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
      lex_mode = MODE_IDLE;
    end else if (c == CH_QUOTE) begin
      lex_start = nxt;
      lex_escape = 1'b0;
      lex_mode = MODE_STRING;
    end else if (c == CH_LBRACE) begin
      add_token(KIND_BRACKET, p, nxt, BR_OPEN_BRACE);
      lex_mode = MODE_IDLE;
    end else if (c == CH_RBRACE) begin
      add_token(KIND_BRACKET, p, nxt, BR_CLOSE_BRACE);
      lex_mode = MODE_IDLE;
    end else if (c == CH_LSQ) begin
      add_token(KIND_BRACKET, p, nxt, BR_OPEN_SQ);
      lex_mode = MODE_IDLE;
    end else if (c == CH_RSQ) begin
      add_token(KIND_BRACKET, p, nxt, BR_CLOSE_SQ);
      lex_mode = MODE_IDLE;
    end else if (c == CH_SLASH) begin
      lex_slash = p;
      lex_mode = MODE_SLASH;
    end else if (is_name_byte(c)) begin
      lex_start = p;
      lex_mode = MODE_NAME;
    end else begin
      add_token(KIND_UNKNOWN, p, p, NO_CODE);
      lex_mode = MODE_DEAD;
    end
  endtask

  // expected tokens for one accepted text byte
  task automatic lex_byte(logic [7:0] c);
    logic [15:0] p;
    logic [15:0] nxt;
    token_t t;
    p = lex_pos;
    nxt = (p != OFFSET_MAX) ? p + 16'd1 : p;
    step_tokens.delete();
    case (lex_mode)
      MODE_NAME: begin
        if (!is_name_byte(c)) begin
          add_token(KIND_NAME, lex_start, p, NO_CODE);
          lex_fresh(c, p, nxt);
        end
      end
      MODE_STRING: begin
        if (c == CH_NUL) begin
          add_token(KIND_UNKNOWN, p, p, NO_CODE);
          lex_end(p);
        end else if (c == CH_LF) begin
          add_token(KIND_UNKNOWN, p, p, NO_CODE);
          lex_mode = MODE_DEAD;
        end else if (c == CH_QUOTE && !lex_escape) begin
          add_token(KIND_STRING, lex_start, p, NO_CODE);
          lex_mode = MODE_IDLE;
        end else begin
          lex_escape = (c == CH_BSL);
        end
      end
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          lex_mode = MODE_LINE;
        end else if (c == CH_STAR) begin
          lex_star = 1'b0;
          lex_mode = MODE_BLOCK;
        end else begin
          add_token(KIND_UNKNOWN, lex_slash, lex_slash, NO_CODE);
          if (c == CH_NUL) lex_end(p);
          else lex_mode = MODE_DEAD;
        end
      end
      MODE_LINE: begin
        if (c == CH_NUL) lex_end(p);
        else if (c == CH_LF) lex_mode = MODE_IDLE;
      end
      MODE_BLOCK: begin
        if (c == CH_NUL) begin
          lex_end(p);
        end else if (c == CH_SLASH && lex_star) begin
          lex_star = 1'b0;
          lex_mode = MODE_IDLE;
        end else begin
          lex_star = (c == CH_STAR);
        end
      end
      MODE_DEAD: begin
        if (c == CH_NUL) lex_end(p);
      end
      default: lex_fresh(c, p, nxt);
    endcase
    if (c != CH_NUL && lex_pos != OFFSET_MAX) lex_pos = lex_pos + 16'd1;
    foreach (step_tokens[i]) begin
      t = step_tokens[i];
      t.last = (i == step_tokens.size() - 1);
      expected_tokens.push_back(t);
    end
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (mismatches < MAX_PRINTED)
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // one input transaction, with random idle cycles ahead of it
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (b == CH_NUL) texts_sent++;
    lex_byte(b);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
  endtask

  // random text, mostly well formed; some texts carry noise pieces
  task automatic compose_text();
    int kind;
    int top;
    logic [7:0] prev;
    logic [7:0] r;
    text_q.delete();
    top = ($urandom_range(3) == 0) ? 99 : 83;
    repeat ($urandom_range(1, 12)) begin
      kind = $urandom_range(top);
      if (kind < 20) begin
        repeat ($urandom_range(1, 8)) text_q.push_back(rand_name_byte());
      end else if (kind < 35) begin
        case ($urandom_range(3))
          0: text_q.push_back(CH_LBRACE);
          1: text_q.push_back(CH_RBRACE);
          2: text_q.push_back(CH_LSQ);
          default: text_q.push_back(CH_RSQ);
        endcase
      end else if (kind < 48) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(3))
            0: text_q.push_back(CH_SPACE);
            1: text_q.push_back(CH_TAB);
            2: text_q.push_back(CH_CR);
            default: text_q.push_back(CH_LF);
          endcase
        end
      end else if (kind < 64) begin
        text_q.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(4) == 0) begin
            text_q.push_back(CH_BSL);
            case ($urandom_range(2))
              0: text_q.push_back(CH_QUOTE);
              1: begin
                // double backslash still escapes the quote after it
                text_q.push_back(CH_BSL);
                text_q.push_back(CH_QUOTE);
              end
              default: text_q.push_back(rand_byte_except(CH_LF, CH_BSL, CH_BSL));
            endcase
          end else begin
            text_q.push_back(rand_byte_except(CH_QUOTE, CH_BSL, CH_LF));
          end
        end
        text_q.push_back(CH_QUOTE);
      end else if (kind < 74) begin
        text_q.push_back(CH_SLASH);
        text_q.push_back(CH_SLASH);
        repeat ($urandom_range(0, 10)) text_q.push_back(rand_byte_except(CH_LF, CH_LF, CH_LF));
        text_q.push_back(CH_LF);
      end else if (kind < 84) begin
        text_q.push_back(CH_SLASH);
        text_q.push_back(CH_STAR);
        prev = CH_SLASH;
        repeat ($urandom_range(0, 10)) begin
          r = ($urandom_range(3) == 0) ? CH_STAR : rand_byte_except(CH_STAR, CH_STAR, CH_STAR);
          if (prev == CH_STAR && r == CH_SLASH) r = CH_STAR;
          text_q.push_back(r);
          prev = r;
        end
        text_q.push_back(CH_STAR);
        text_q.push_back(CH_SLASH);
      end else if (kind < 90) begin
        text_q.push_back(8'($urandom_range(1, 255)));
      end else if (kind < 95) begin
        text_q.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 3)) text_q.push_back(rand_byte_except(CH_QUOTE, CH_BSL, CH_LF));
        text_q.push_back(CH_LF);
      end else begin
        text_q.push_back(CH_SLASH);
        text_q.push_back(rand_byte_except(CH_SLASH, CH_STAR, CH_STAR));
      end
    end
    // text cut off inside a string, after a slash or inside a comment
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: text_q.push_back(CH_QUOTE);
        1: text_q.push_back(CH_SLASH);
        2: begin
          text_q.push_back(CH_SLASH);
          text_q.push_back(CH_STAR);
        end
        default: begin
          text_q.push_back(CH_SLASH);
          text_q.push_back(CH_SLASH);
        end
      endcase
    end
    text_q.push_back(CH_NUL);
  endtask

  task automatic run_random_texts(int n);
    int stop_at;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      compose_text();
      foreach (text_q[i]) begin
        if ($urandom_range(199) == 0) wait_drain();
        send_byte(text_q[i]);
      end
    end
  endtask

  task automatic test_directed_cases();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    // name closed by a bracket, all brackets, whitespace, escaped quotes
    send_text("a{} [");
    send_byte(CH_TAB);
    send_text("]\"\\\\\"x\"");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_NUL);
    // opening star does not close, then an unclosed line comment
    send_text("/*/*///");
    send_byte(CH_NUL);
    // string broken by newline, then by end of text
    send_text("\"\n");
    send_byte(CH_NUL);
    send_byte(CH_QUOTE);
    send_byte(CH_NUL);
    // lone slash at end, then an unknown top byte
    send_byte(CH_SLASH);
    send_byte(CH_NUL);
    send_byte(8'hff);
    send_byte(CH_NUL);
  endtask

  task automatic test_random_no_idle();
    wait_drain();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    run_random_texts(PHASE_BYTES);
  endtask

  task automatic test_random_sender_idle();
    wait_drain();
    src_idle_pct = 67;
    sink_stall_pct = 0;
    run_random_texts(PHASE_BYTES);
  endtask

  task automatic test_random_receiver_stall();
    wait_drain();
    src_idle_pct = 0;
    sink_stall_pct = 67;
    run_random_texts(PHASE_BYTES);
  endtask

  task automatic test_random_both_idle();
    wait_drain();
    src_idle_pct = 16;
    sink_stall_pct = 16;
    run_random_texts(PHASE_BYTES);
  endtask

  // receiver side: random stalls and token check
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch("token with nothing expected, kind", 16'(m_tuser), 16'd0);
      end else begin
        want_tok = expected_tokens.pop_front();
        tokens_checked++;
        if (m_tuser !== want_tok.kind)
          report_mismatch("token_kind", 16'(m_tuser), 16'(want_tok.kind));
        if (m_tdata[15:0] !== want_tok.tbegin)
          report_mismatch("token_begin", m_tdata[15:0], want_tok.tbegin);
        if (m_tdata[31:16] !== want_tok.tfinish)
          report_mismatch("token_finish", m_tdata[31:16], want_tok.tfinish);
        if (m_tdata[33:32] !== want_tok.code)
          report_mismatch("bracket_code", 16'(m_tdata[33:32]), 16'(want_tok.code));
        if (m_tlast !== want_tok.last)
          report_mismatch("last_of_run", 16'(m_tlast), 16'(want_tok.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d tokens outstanding",
               idle_cycles, expected_tokens.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    clear_text_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d bytes in %0d texts, checked %0d tokens, %0d mismatches",
             bytes_sent, texts_sent, tokens_checked, mismatches);
    $display("covered directed edge cases and random texts with sender gaps and receiver stalls");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
